>>> design/flexpage_size_and_base_calc_top_macros.svh
// Assertion macros used by the top design file.
`ifndef FLEXPAGE_SIZE_AND_BASE_CALC_TOP_MACROS_SVH
`define FLEXPAGE_SIZE_AND_BASE_CALC_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define FPSB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define FPSB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FPSB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define FPSB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> design/fpsb_pkg.sv
package fpsb_pkg;

    localparam int FIELD_W = 32;
    localparam int LOG_W   = 6;
    localparam int LG_W    = 7;

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    typedef logic [LG_W-1:0] t_lg;

    typedef struct packed {
        logic hi;
        logic ovr;
        t_lg  ovr_val;
    } t_lane_ctl;

    typedef struct packed {
        t_lg  want;
        t_lg  win;
        logic wr;
        logic part;
        logic more;
    } t_side_ctl;

    typedef struct packed {
        logic               status;
        logic [FIELD_W-1:0] page_base;
        logic [LOG_W-1:0]   page_log2;
        logic               writable;
        logic [FIELD_W-1:0] send_base;
    } t_rsp;

endpackage

>>> design/fpsb_if.sv
interface fpsb_req_if;
    import fpsb_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] area_base;
    logic [FIELD_W-1:0] area_len;
    logic [FIELD_W-1:0] area_ofs;
    logic [LOG_W-1:0]   want_log2;
    logic [LOG_W-1:0]   window_log2;
    logic [FIELD_W-1:0] window_offset;
    logic               write_req;
    logic               allow_partial;
    logic               allow_more;

    modport source (
        output valid, area_base, area_len, area_ofs, want_log2, window_log2,
               window_offset, write_req, allow_partial, allow_more,
        input  ready
    );
    modport sink (
        input  valid, area_base, area_len, area_ofs, want_log2, window_log2,
               window_offset, write_req, allow_partial, allow_more,
        output ready
    );
endinterface

interface fpsb_rsp_if;
    import fpsb_pkg::*;

    logic               valid;
    logic               ready;
    logic               status;
    logic [FIELD_W-1:0] page_base;
    logic [LOG_W-1:0]   page_log2;
    logic               writable;
    logic [FIELD_W-1:0] send_base;

    modport source (
        output valid, status, page_base, page_log2, writable, send_base,
        input  ready
    );
    modport sink (
        input  valid, status, page_base, page_log2, writable, send_base,
        output ready
    );
endinterface

>>> design/fpsb_front.sv
module fpsb_front #(
    parameter int ADDR_BITS  = 32,
    parameter int SPACE_LOG2 = 32
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [fpsb_pkg::FIELD_W-1:0]    i_area_base,
    input  logic [fpsb_pkg::FIELD_W-1:0]    i_area_len,
    input  logic [fpsb_pkg::FIELD_W-1:0]    i_area_ofs,
    input  logic [fpsb_pkg::LOG_W-1:0]      i_want_log2,
    input  logic [fpsb_pkg::LOG_W-1:0]      i_window_log2,
    input  logic [fpsb_pkg::FIELD_W-1:0]    i_window_offset,
    input  logic                            i_write_req,
    input  logic                            i_allow_partial,
    input  logic                            i_allow_more,
    output logic [ADDR_BITS-1:0]            o_op_a,
    output logic [ADDR_BITS-1:0]            o_op_b,
    output logic [ADDR_BITS-1:0]            o_op_c,
    output fpsb_pkg::t_lane_ctl             o_ctl_a,
    output fpsb_pkg::t_lane_ctl             o_ctl_b,
    output fpsb_pkg::t_lane_ctl             o_ctl_c,
    output logic [ADDR_BITS-1:0]            o_local,
    output logic [ADDR_BITS-1:0]            o_woff,
    output fpsb_pkg::t_side_ctl             o_side
);
    import fpsb_pkg::*;

    localparam t_lg SPACE = LG_W'(SPACE_LOG2);

    logic [ADDR_BITS-1:0] n_base, n_size, n_offs, n_woff;
    logic [ADDR_BITS-1:0] r_base, r_local, r_end, r_diff, r_woff;
    t_side_ctl            n_side, r_side;

    logic [ADDR_BITS-1:0] n_op_a, n_op_b, n_op_c, w_or;
    t_lane_ctl            n_ctl_a, n_ctl_b, n_ctl_c;
    logic                 w_eq_a, w_eq_b;

    logic [ADDR_BITS-1:0] r_op_a, r_op_b, r_op_c, r2_local, r2_woff;
    t_lane_ctl            r_ctl_a, r_ctl_b, r_ctl_c;
    t_side_ctl            r2_side;

    always_comb begin
        n_base      = ADDR_BITS'(i_area_base);
        n_size      = ADDR_BITS'(i_area_len);
        n_offs      = ADDR_BITS'(i_area_ofs);
        n_woff      = ADDR_BITS'(i_window_offset);
        n_side.want = LG_W'(i_want_log2);
        n_side.win  = LG_W'(i_window_log2);
        n_side.wr   = i_write_req;
        n_side.part = i_allow_partial;
        n_side.more = i_allow_more;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_base  <= n_base;
            r_local <= n_base + n_offs;
            r_end   <= n_base + n_size;
            r_diff  <= n_size - n_offs;
            r_woff  <= n_woff;
            r_side  <= n_side;
        end
    end

    // In more mode the first two lanes scan the ranges below and above the
    // local address; otherwise they scan the remaining length and the
    // joint alignment of the local address and the window offset.
    always_comb begin
        w_eq_a = (r_base == r_local);
        w_eq_b = (r_local == r_end);
        w_or   = r_local | r_woff;

        if (r_side.more) begin
            n_op_a          = w_eq_a ? r_base : ((r_base - ADDR_BITS'(1)) ^ r_local);
            n_ctl_a.hi      = !w_eq_a;
            n_ctl_a.ovr     = w_eq_a && (r_base == '0);
            n_ctl_a.ovr_val = SPACE;
            n_op_b          = w_eq_b ? r_local : ((r_local - ADDR_BITS'(1)) ^ r_end);
            n_ctl_b.hi      = !w_eq_b;
            n_ctl_b.ovr     = w_eq_b && (r_local == '0);
            n_ctl_b.ovr_val = SPACE;
        end else begin
            n_op_a          = r_diff;
            n_ctl_a.hi      = 1'b1;
            n_ctl_a.ovr     = 1'b0;
            n_ctl_a.ovr_val = SPACE;
            n_op_b          = w_or;
            n_ctl_b.hi      = 1'b0;
            n_ctl_b.ovr     = (w_or == '0);
            n_ctl_b.ovr_val = r_side.win;
        end

        n_op_c          = r_local ^ r_woff;
        n_ctl_c.hi      = 1'b0;
        n_ctl_c.ovr     = (r_local == r_woff);
        n_ctl_c.ovr_val = r_side.win;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_op_a   <= n_op_a;
            r_op_b   <= n_op_b;
            r_op_c   <= n_op_c;
            r_ctl_a  <= n_ctl_a;
            r_ctl_b  <= n_ctl_b;
            r_ctl_c  <= n_ctl_c;
            r2_local <= r_local;
            r2_woff  <= r_woff;
            r2_side  <= r_side;
        end
    end

    assign o_op_a  = r_op_a;
    assign o_op_b  = r_op_b;
    assign o_op_c  = r_op_c;
    assign o_ctl_a = r_ctl_a;
    assign o_ctl_b = r_ctl_b;
    assign o_ctl_c = r_ctl_c;
    assign o_local = r2_local;
    assign o_woff  = r2_woff;
    assign o_side  = r2_side;

endmodule

>>> design/fpsb_scan.sv
module fpsb_scan #(
    parameter int W = 32
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [W-1:0]        i_op,
    input  fpsb_pkg::t_lane_ctl i_ctl,
    output fpsb_pkg::t_lg       o_res
);
    import fpsb_pkg::*;

    localparam int G  = (W + 7) / 8;
    localparam int PW = G * 8;

    logic [W-1:0]  w_rev, w_v;
    logic [PW-1:0] w_pv;
    logic [G-1:0]  n_nz, r_nz;
    logic [2:0]    n_gi [G];
    logic [2:0]    r_gi [G];
    t_lane_ctl     r_ctl;

    t_lg  w_pos, w_idx;
    logic w_any;
    t_lg  r_res;

    // A low scan runs as a high scan of the bit-reversed operand.
    always_comb begin
        for (int i = 0; i < W; i++) begin
            w_rev[i] = i_op[W-1-i];
        end
        w_v  = i_ctl.hi ? i_op : w_rev;
        w_pv = PW'(w_v);
        for (int g = 0; g < G; g++) begin
            n_nz[g] = |w_pv[g*8 +: 8];
            n_gi[g] = 3'd0;
            for (int b = 0; b < 8; b++) begin
                if (w_pv[g*8+b]) begin
                    n_gi[g] = 3'(b);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nz  <= n_nz;
            r_gi  <= n_gi;
            r_ctl <= i_ctl;
        end
    end

    always_comb begin
        w_pos = '0;
        w_any = |r_nz;
        for (int g = 0; g < G; g++) begin
            if (r_nz[g]) begin
                w_pos = LG_W'(g * 8) | LG_W'(r_gi[g]);
            end
        end
        w_idx = r_ctl.hi ? w_pos : (LG_W'(W - 1) - w_pos);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= r_ctl.ovr ? r_ctl.ovr_val : (w_any ? w_idx : '0);
        end
    end

    assign o_res = r_res;

endmodule

>>> design/fpsb_back.sv
module fpsb_back #(
    parameter int ADDR_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  fpsb_pkg::t_lg           i_res_a,
    input  fpsb_pkg::t_lg           i_res_b,
    input  fpsb_pkg::t_lg           i_res_c,
    input  logic [ADDR_BITS-1:0]    i_local,
    input  logic [ADDR_BITS-1:0]    i_woff,
    input  fpsb_pkg::t_side_ctl     i_side,
    output fpsb_pkg::t_rsp          o_rsp
);
    import fpsb_pkg::*;

    t_lg  w_ab, w_bw, w_cw, w_more, w_plain, n_fs;
    logic n_err;

    t_lg                  r_fs;
    logic                 r_err, r_wr;
    logic [ADDR_BITS-1:0] r_local, r_woff;

    logic [ADDR_BITS-1:0] w_mask, w_start, w_send;
    t_rsp                 n_rsp, r_rsp;

    always_comb begin
        w_ab    = (i_res_a < i_res_b) ? i_res_a : i_res_b;
        w_cw    = (i_res_c < i_side.win) ? i_res_c : i_side.win;
        w_bw    = (i_res_b < i_side.win) ? i_res_b : i_side.win;
        w_more  = (w_ab < w_cw) ? w_ab : w_cw;
        w_plain = (i_res_a < w_bw) ? i_res_a : w_bw;
        if (w_plain > i_side.want) begin
            w_plain = i_side.want;
        end
        n_fs  = i_side.more ? w_more : w_plain;
        n_err = (n_fs < i_side.want) && !i_side.part;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fs    <= n_fs;
            r_err   <= n_err;
            r_wr    <= i_side.wr;
            r_local <= i_local;
            r_woff  <= i_woff;
        end
    end

    always_comb begin
        for (int i = 0; i < ADDR_BITS; i++) begin
            w_mask[i] = (LG_W'(i) < r_fs);
        end
        w_start = r_local & ~w_mask;
        w_send  = r_woff - (r_local & w_mask);
        if (r_err) begin
            n_rsp = '0;
            n_rsp.status = ST_ERR;
        end else begin
            n_rsp.status    = ST_OK;
            n_rsp.page_base = FIELD_W'(w_start);
            n_rsp.page_log2 = r_fs[LOG_W-1:0];
            n_rsp.writable  = r_wr;
            n_rsp.send_base = FIELD_W'(w_send);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp = r_rsp;

endmodule

>>> design/flexpage_size_and_base_calc_top.sv
// Throughput: one item per cycle; the six register stages (operand sums,
// scan operands, two bit-scan stages, size selection, base and send base)
// advance together and hold as a whole while the output item is not taken.
// Reset: synchronous, active low; it clears the stage valid bits only.
`include "flexpage_size_and_base_calc_top_macros.svh"

module flexpage_size_and_base_calc_top #(
    parameter int ADDR_BITS  = 32,
    parameter int SPACE_LOG2 = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fpsb_req_if.sink    i_req,
    fpsb_rsp_if.source  o_rsp
);
    import fpsb_pkg::*;

    localparam int NS = 6;

    logic [NS-1:0] r_vld;
    logic          w_adv;

    logic [ADDR_BITS-1:0] w_op_a, w_op_b, w_op_c, w_local, w_woff;
    t_lane_ctl            w_ctl_a, w_ctl_b, w_ctl_c;
    t_side_ctl            w_side;
    t_lg                  w_res_a, w_res_b, w_res_c;

    logic [ADDR_BITS-1:0] r_local_d1, r_local_d2, r_woff_d1, r_woff_d2;
    t_side_ctl            r_side_d1, r_side_d2;
    t_rsp                 w_rsp;

    assign w_adv       = !r_vld[NS-1] || o_rsp.ready;
    assign i_req.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NS-2:0], i_req.valid};
        end
    end

    fpsb_front #(
        .ADDR_BITS  (ADDR_BITS),
        .SPACE_LOG2 (SPACE_LOG2)
    ) u_front (
        .i_clk           (i_clk),
        .i_en            (w_adv),
        .i_area_base     (i_req.area_base),
        .i_area_len      (i_req.area_len),
        .i_area_ofs      (i_req.area_ofs),
        .i_want_log2     (i_req.want_log2),
        .i_window_log2   (i_req.window_log2),
        .i_window_offset (i_req.window_offset),
        .i_write_req     (i_req.write_req),
        .i_allow_partial (i_req.allow_partial),
        .i_allow_more    (i_req.allow_more),
        .o_op_a          (w_op_a),
        .o_op_b          (w_op_b),
        .o_op_c          (w_op_c),
        .o_ctl_a         (w_ctl_a),
        .o_ctl_b         (w_ctl_b),
        .o_ctl_c         (w_ctl_c),
        .o_local         (w_local),
        .o_woff          (w_woff),
        .o_side          (w_side)
    );

    fpsb_scan #(.W(ADDR_BITS)) u_scan_a (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_op  (w_op_a),
        .i_ctl (w_ctl_a),
        .o_res (w_res_a)
    );

    fpsb_scan #(.W(ADDR_BITS)) u_scan_b (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_op  (w_op_b),
        .i_ctl (w_ctl_b),
        .o_res (w_res_b)
    );

    fpsb_scan #(.W(ADDR_BITS)) u_scan_c (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_op  (w_op_c),
        .i_ctl (w_ctl_c),
        .o_res (w_res_c)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_local_d1 <= w_local;
            r_local_d2 <= r_local_d1;
            r_woff_d1  <= w_woff;
            r_woff_d2  <= r_woff_d1;
            r_side_d1  <= w_side;
            r_side_d2  <= r_side_d1;
        end
    end

    fpsb_back #(.ADDR_BITS(ADDR_BITS)) u_back (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_res_a (w_res_a),
        .i_res_b (w_res_b),
        .i_res_c (w_res_c),
        .i_local (r_local_d2),
        .i_woff  (r_woff_d2),
        .i_side  (r_side_d2),
        .o_rsp   (w_rsp)
    );

    assign o_rsp.valid     = r_vld[NS-1];
    assign o_rsp.status    = w_rsp.status;
    assign o_rsp.page_base = w_rsp.page_base;
    assign o_rsp.page_log2 = w_rsp.page_log2;
    assign o_rsp.writable  = w_rsp.writable;
    assign o_rsp.send_base = w_rsp.send_base;

    `FPSB_ASSERT_IMPL(a_err_fields_zero, i_clk, i_rst_n,
        o_rsp.valid && o_rsp.status == ST_ERR,
        o_rsp.page_base == '0 && o_rsp.page_log2 == '0 && !o_rsp.writable
            && o_rsp.send_base == '0)
    `FPSB_ASSERT_IMPL(a_whole_space_base, i_clk, i_rst_n,
        o_rsp.valid && o_rsp.status == ST_OK && o_rsp.page_log2 >= ADDR_BITS,
        o_rsp.page_base == '0)
    `FPSB_ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n,
        !i_req.ready, o_rsp.valid && !o_rsp.ready)
    `FPSB_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n,
        i_req.valid && i_req.ready, r_vld[0])

endmodule
